FILE: design/jsi_pkg.sv
// Shared types, character codes and constants for the JSON stream indenter.
package jsi_pkg;

    // Default and bounds
    localparam int MAX_DEPTH_DEF = 16;
    localparam int MAX_SPACES    = 48;
    localparam int SPACE_W       = 6;
    localparam int CMDQ_DEPTH    = 4;
    localparam int CFG_W         = 2;
    localparam logic [CFG_W-1:0] INDENT_RESET = 2'd2;

    // Character codes
    localparam logic [7:0] CHR_QUOTE  = 8'h22;
    localparam logic [7:0] CHR_BSLASH = 8'h5C;
    localparam logic [7:0] CHR_COMMA  = 8'h2C;
    localparam logic [7:0] CHR_LBRACE = 8'h7B;
    localparam logic [7:0] CHR_LBRACK = 8'h5B;
    localparam logic [7:0] CHR_RBRACE = 8'h7D;
    localparam logic [7:0] CHR_RBRACK = 8'h5D;
    localparam logic [7:0] CHR_NL     = 8'h0A;
    localparam logic [7:0] CHR_SPACE  = 8'h20;
    localparam logic [7:0] CHR_TAB    = 8'h09;
    localparam logic [7:0] CHR_VT     = 8'h0B;
    localparam logic [7:0] CHR_FF     = 8'h0C;
    localparam logic [7:0] CHR_CR     = 8'h0D;

    // Shape of the output run for one item
    typedef enum logic [1:0] {
        CMD_SINGLE,  // byte only
        CMD_AFTER,   // byte, newline, indent
        CMD_BEFORE   // newline, indent, byte
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [7:0]         data;
        logic [SPACE_W-1:0] spaces;
        logic               fault;
    } jsi_cmd_t;

    // Front parser status
    typedef struct packed {
        logic in_string;
        logic escape_pending;
    } front_stat_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_HEAD,
        BK_NL,
        BK_SPACE,
        BK_TAIL
    } back_state_t;

endpackage

FILE: design/jsi_front.sv
// Front end: accepts input bytes, tracks string and nesting state, builds commands.
module jsi_front #(
    parameter int MAX_DEPTH = jsi_pkg::MAX_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [7:0]                 in_byte,
    input  logic [jsi_pkg::CFG_W-1:0]  indent_width,
    output logic                       cmd_push,
    output jsi_pkg::jsi_cmd_t          cmd,
    output jsi_pkg::front_stat_t       stat
);
    import jsi_pkg::*;

    localparam int NEST_W = $clog2(MAX_DEPTH + 1);

    logic              in_string_reg, in_string_next;
    logic              escape_reg, escape_next;
    logic [NEST_W-1:0] level_reg, level_next;
    logic              keep;
    logic              fault;
    cmd_kind_t         kind;
    logic [NEST_W+1:0] prod;
    logic [SPACE_W-1:0] spaces;

    // Classify the byte and work out the next parser state
    always_comb
    begin
        in_string_next = in_string_reg;
        escape_next    = escape_reg;
        level_next     = level_reg;
        keep           = 1'b1;
        fault          = 1'b0;
        kind           = CMD_SINGLE;
        if (in_string_reg)
        begin
            if (escape_reg)
                escape_next = 1'b0;
            else if (in_byte == CHR_QUOTE)
                in_string_next = 1'b0;
            else if (in_byte == CHR_BSLASH)
                escape_next = 1'b1;
        end
        else
        begin
            unique case (in_byte) inside
                CHR_QUOTE:
                    in_string_next = 1'b1;
                CHR_COMMA:
                    kind = CMD_AFTER;
                CHR_LBRACE, CHR_LBRACK:
                begin
                    kind = CMD_AFTER;
                    if (level_reg >= NEST_W'(MAX_DEPTH))
                    begin
                        level_next = NEST_W'(MAX_DEPTH);
                        fault      = 1'b1;
                    end
                    else
                        level_next = level_reg + 1'b1;
                end
                CHR_RBRACE, CHR_RBRACK:
                begin
                    kind = CMD_BEFORE;
                    if (level_reg == '0)
                        fault = 1'b1;
                    else
                        level_next = level_reg - 1'b1;
                end
                CHR_SPACE, CHR_TAB, CHR_NL, CHR_VT, CHR_FF, CHR_CR:
                    keep = 1'b0;
                default:
                    kind = CMD_SINGLE;
            endcase
        end
    end

    // Indent length at the new depth, capped
    always_comb
    begin
        prod = (NEST_W+2)'(indent_width) * (NEST_W+2)'(level_next);
        if (int'(prod) > MAX_SPACES)
            spaces = SPACE_W'(MAX_SPACES);
        else
            spaces = SPACE_W'(prod);
    end

    assign cmd_push    = accept && keep;
    assign cmd.kind    = kind;
    assign cmd.data    = in_byte;
    assign cmd.spaces  = spaces;
    assign cmd.fault   = fault;
    assign stat.in_string      = in_string_reg;
    assign stat.escape_pending = escape_reg;

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_string_reg <= 1'b0;
            escape_reg    <= 1'b0;
            level_reg     <= '0;
        end
        else if (accept)
        begin
            in_string_reg <= in_string_next;
            escape_reg    <= escape_next;
            level_reg     <= level_next;
        end
    end

endmodule

FILE: design/jsi_cmdq.sv
// Short command queue between front and back end.
module jsi_cmdq #(
    parameter int DEPTH = jsi_pkg::CMDQ_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  jsi_pkg::jsi_cmd_t wr_data,
    input  logic              rd_en,
    output jsi_pkg::jsi_cmd_t rd_data,
    output logic              rd_valid,
    output logic              full
);
    import jsi_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    jsi_cmd_t           slot [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_wr, do_rd;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot[wr_ptr_reg] <= wr_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: design/jsi_back.sv
// Back end: expands each command into output bytes, one per cycle while the output register is free.
module jsi_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  jsi_pkg::jsi_cmd_t cmd,
    output logic              cmd_pop,
    output logic              empty,
    input  logic              pop,
    output logic [7:0]        out_byte,
    output logic              last_of_run,
    output logic              depth_fault
);
    import jsi_pkg::*;

    back_state_t        state_reg, state_next;
    cmd_kind_t          kind_reg;
    logic [7:0]         data_reg;
    logic [SPACE_W-1:0] spaces_reg;
    logic               fault_reg;
    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               out_last_reg;
    logic               out_fault_reg;
    logic               adv;
    logic               emit;
    logic [7:0]         emit_byte;
    logic               emit_last;
    logic               spaces_dec;

    // Output slot free this cycle
    assign adv = !out_valid_reg || pop;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
                if (cmd_valid)
                    state_next = (cmd.kind == CMD_BEFORE) ? BK_NL : BK_HEAD;
            BK_HEAD:
                if (adv)
                    state_next = (kind_reg == CMD_SINGLE) ? BK_IDLE : BK_NL;
            BK_NL:
                if (adv)
                begin
                    if (spaces_reg != '0)
                        state_next = BK_SPACE;
                    else
                        state_next = (kind_reg == CMD_AFTER) ? BK_IDLE : BK_TAIL;
                end
            BK_SPACE:
                if (adv && spaces_reg == SPACE_W'(1))
                    state_next = (kind_reg == CMD_AFTER) ? BK_IDLE : BK_TAIL;
            BK_TAIL:
                if (adv)
                    state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        cmd_pop    = 1'b0;
        emit       = 1'b0;
        emit_byte  = data_reg;
        emit_last  = 1'b0;
        spaces_dec = 1'b0;
        unique case (state_reg)
            BK_IDLE:
                cmd_pop = cmd_valid;
            BK_HEAD:
            begin
                emit      = adv;
                emit_last = (kind_reg == CMD_SINGLE);
            end
            BK_NL:
            begin
                emit      = adv;
                emit_byte = CHR_NL;
                emit_last = (kind_reg == CMD_AFTER) && (spaces_reg == '0);
            end
            BK_SPACE:
            begin
                emit       = adv;
                emit_byte  = CHR_SPACE;
                emit_last  = (kind_reg == CMD_AFTER) && (spaces_reg == SPACE_W'(1));
                spaces_dec = adv;
            end
            BK_TAIL:
            begin
                emit      = adv;
                emit_last = 1'b1;
            end
            default:
                emit = 1'b0;
        endcase
    end

    // Current command
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            kind_reg   <= cmd.kind;
            data_reg   <= cmd.data;
            spaces_reg <= cmd.spaces;
            fault_reg  <= cmd.fault;
        end
        else if (spaces_dec)
            spaces_reg <= spaces_reg - 1'b1;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg  <= emit_byte;
            out_last_reg  <= emit_last;
            out_fault_reg <= fault_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    assign empty       = !out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;
    assign depth_fault = out_fault_reg;

endmodule

FILE: design/json_stream_indenter_core.sv
// Top level of the JSON stream indenter: config register, front, queue and back end.
//
// Re-indents compact JSON text one byte at a time.
// Input queue side: present in_byte with push; it is taken on an edge where push
// is high and full is low. Whitespace outside strings is taken and dropped.
// Output queue side: while empty is low, out_byte, last_of_run and depth_fault
// show the oldest result; pop on an edge where empty is low takes it.
// last_of_run marks the final byte produced for one input item.
// Config: cfg_data (spaces per level) is written when cfg_valid is high;
// cfg_ready is always high. Write it only while the block is idle.
// With an empty pipeline, a taken item passes the command queue, the back end's
// command register and the output register before its first result shows.
// The back end emits one byte per cycle while the output register is free, and
// fetches each command in its idle state, taking a new one only after the last
// command's final byte. A four-entry command queue lets input run ahead at one
// item per cycle until it fills.
// Reset clears parser state, queue and output register; the indent width
// returns to two. If the receiver stops popping, the output register holds
// its item, the queue fills and full rises; nothing is lost.
module json_stream_indenter_core #(
    parameter int MAX_DEPTH  = jsi_pkg::MAX_DEPTH_DEF,
    parameter int CMDQ_DEPTH = jsi_pkg::CMDQ_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [7:0]                in_byte,
    output logic                      empty,
    input  logic                      pop,
    output logic [7:0]                out_byte,
    output logic                      last_of_run,
    output logic                      depth_fault,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [jsi_pkg::CFG_W-1:0] cfg_data
);
    import jsi_pkg::*;

    logic [CFG_W-1:0] indent_width_reg;
    logic             accept;
    logic             cmd_push;
    jsi_cmd_t         push_cmd;
    jsi_cmd_t         head_cmd;
    logic             cmd_valid;
    logic             cmd_pop;
    logic             cmd_full;
    front_stat_t      front_stat;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            indent_width_reg <= INDENT_RESET;
        else if (cfg_valid && cfg_ready)
            indent_width_reg <= cfg_data;
    end

    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    jsi_front #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .in_byte      (in_byte),
        .indent_width (indent_width_reg),
        .cmd_push     (cmd_push),
        .cmd          (push_cmd),
        .stat         (front_stat)
    );

    jsi_cmdq #(
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_push),
        .wr_data  (push_cmd),
        .rd_en    (cmd_pop),
        .rd_data  (head_cmd),
        .rd_valid (cmd_valid),
        .full     (cmd_full)
    );

    jsi_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (head_cmd),
        .cmd_pop     (cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .depth_fault (depth_fault)
    );

    // An escape can only be pending inside a string
    a_escape_in_string: assert property (@(posedge clk) disable iff (!rst_n)
        front_stat.escape_pending |-> front_stat.in_string)
        else $error("escape pending outside a string");

    // Commands are never written into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full)
        else $error("command queue overflow");

    // A full input side means commands are waiting for the back end
    a_full_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> cmd_valid)
        else $error("full raised with empty command queue");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the JSON stream indenter core.
`timescale 1ns / 100ps

module tb_top;

    import jsi_pkg::*;

    localparam int NEST_MAX   = MAX_DEPTH_DEF;
    localparam int STALL_MAX  = 2000;  // cycles with no handshake before giving up
    localparam int DRAIN_WAIT = 12;    // covers the output pipeline and a dropped tail

    // one formatted byte as the block should produce it
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       fault;
    } fmt_byte_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    logic [7:0]       in_byte = 8'h00;
    logic             empty;
    logic             pop = 1'b0;
    logic [7:0]       out_byte;
    logic             last_of_run;
    logic             depth_fault;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;

    // source text still to send, and formatted bytes still owed
    logic [7:0] pend_bytes[$];
    fmt_byte_t  owed_bytes[$];

    // mirror of the parser state and of the indent register
    logic             str_open = 1'b0;
    logic             esc_next = 1'b0;
    int               nest_lvl = 0;
    logic [CFG_W-1:0] spaces_per_lvl = INDENT_RESET;

    int err_cnt = 0;
    int quiet_cycles = 0;
    int send_idle = 0;
    int recv_idle = 0;

    json_stream_indenter_core #(
        .MAX_DEPTH(NEST_MAX)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_byte    (in_byte),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .last_of_run(last_of_run),
        .depth_fault(depth_fault),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Work out the formatted run for one source byte and queue it
    function automatic void format_byte(input logic [7:0] c);
        logic [7:0] run[$];
        logic       fault;
        int         n_sp;
        fault = 1'b0;
        if (str_open)
        begin
            if (esc_next)
                esc_next = 1'b0;
            else if (c == CHR_QUOTE)
                str_open = 1'b0;
            else if (c == CHR_BSLASH)
                esc_next = 1'b1;
            run.push_back(c);
        end
        else if (c == CHR_QUOTE)
        begin
            str_open = 1'b1;
            run.push_back(c);
        end
        else if (c == CHR_COMMA || c == CHR_LBRACE || c == CHR_LBRACK)
        begin
            if (c != CHR_COMMA)
            begin
                if (nest_lvl >= NEST_MAX)
                begin
                    nest_lvl = NEST_MAX;
                    fault = 1'b1;
                end
                else
                    nest_lvl++;
            end
            n_sp = int'(spaces_per_lvl) * nest_lvl;
            if (n_sp > MAX_SPACES)
                n_sp = MAX_SPACES;
            run.push_back(c);
            run.push_back(CHR_NL);
            repeat (n_sp) run.push_back(CHR_SPACE);
        end
        else if (c == CHR_RBRACE || c == CHR_RBRACK)
        begin
            if (nest_lvl == 0)
                fault = 1'b1;
            else
                nest_lvl--;
            n_sp = int'(spaces_per_lvl) * nest_lvl;
            if (n_sp > MAX_SPACES)
                n_sp = MAX_SPACES;
            run.push_back(CHR_NL);
            repeat (n_sp) run.push_back(CHR_SPACE);
            run.push_back(c);
        end
        else if (!(c == CHR_SPACE || c == CHR_TAB || c == CHR_NL || c == CHR_VT ||
                   c == CHR_FF || c == CHR_CR))
            run.push_back(c);
        foreach (run[k])
            owed_bytes.push_back('{data: run[k], last: (k == run.size() - 1), fault: fault});
    endfunction

    // Sender: present the next source byte, hold it while full is high
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push    <= 1'b0;
            in_byte <= 8'h00;
        end
        else
        begin
            if (push && !full)
                format_byte(in_byte);
            if (!push || !full)
            begin
                if (pend_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    push    <= 1'b1;
                    in_byte <= pend_bytes.pop_front();
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Receiver: take results at random and compare with the oldest owed byte
    always @(posedge clk or negedge rst_n)
    begin
        fmt_byte_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (owed_bytes.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: result with none owed: expected nothing, got %h/%b/%b",
                             $time, out_byte, last_of_run, depth_fault);
                end
                else
                begin
                    want = owed_bytes.pop_front();
                    if (out_byte !== want.data || last_of_run !== want.last ||
                        depth_fault !== want.fault)
                    begin
                        err_cnt++;
                        $display("%0t: byte/last/fault expected %h/%b/%b, got %h/%b/%b",
                                 $time, want.data, want.last, want.fault,
                                 out_byte, last_of_run, depth_fault);
                    end
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_MAX)
            begin
                $display("json_stream_indenter_core verification failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Append random JSON-like text: mostly well-formed pieces, some noise
    task automatic queue_text(input int target, input bit deep_first);
        int         added;
        int         pick;
        int         k;
        int         len;
        logic [7:0] ch;
        string      tok;
        added = 0;
        tok = "0123456789truefalsn:-.e";
        while (added < target)
        begin
            pick = deep_first ? 0 : $urandom_range(0, 99);
            deep_first = 1'b0;
            if (pick < 8)
            begin
                // deep nesting, sometimes past the limit and back under zero
                k = $urandom_range(14, 19);
                repeat (k) pend_bytes.push_back($urandom_range(0, 1) ? CHR_LBRACE : CHR_LBRACK);
                repeat (k) pend_bytes.push_back($urandom_range(0, 1) ? CHR_RBRACE : CHR_RBRACK);
                added += 2 * k;
            end
            else if (pick < 30)
            begin
                // quoted string with occasional escapes
                pend_bytes.push_back(CHR_QUOTE);
                len = $urandom_range(0, 6);
                repeat (len)
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        pend_bytes.push_back(CHR_BSLASH);
                        pend_bytes.push_back(8'($urandom_range(0, 255)));
                        added += 2;
                    end
                    else
                    begin
                        ch = 8'($urandom_range(32, 126));
                        if (ch == CHR_QUOTE || ch == CHR_BSLASH)
                            ch = 8'h5F;
                        pend_bytes.push_back(ch);
                        added++;
                    end
                end
                pend_bytes.push_back(CHR_QUOTE);
                added += 2;
            end
            else if (pick < 44)
            begin
                pend_bytes.push_back($urandom_range(0, 1) ? CHR_LBRACE : CHR_LBRACK);
                added++;
            end
            else if (pick < 58)
            begin
                pend_bytes.push_back($urandom_range(0, 1) ? CHR_RBRACE : CHR_RBRACK);
                added++;
            end
            else if (pick < 70)
            begin
                pend_bytes.push_back(CHR_COMMA);
                added++;
            end
            else if (pick < 78)
            begin
                // blanks are dropped, so not counted
                case ($urandom_range(0, 5))
                    0: pend_bytes.push_back(CHR_SPACE);
                    1: pend_bytes.push_back(CHR_TAB);
                    2: pend_bytes.push_back(CHR_NL);
                    3: pend_bytes.push_back(CHR_VT);
                    4: pend_bytes.push_back(CHR_FF);
                    default: pend_bytes.push_back(CHR_CR);
                endcase
            end
            else if (pick < 90)
            begin
                len = $urandom_range(1, 4);
                repeat (len) pend_bytes.push_back(8'(tok[$urandom_range(0, tok.len() - 1)]));
                added += len;
            end
            else
            begin
                pend_bytes.push_back(8'($urandom_range(0, 255)));
                added++;
            end
        end
    endtask

    // Wait until all text is sent and every owed byte has come back;
    // checked between edges so that the sender and receiver have settled
    task automatic wait_drained();
        while (pend_bytes.size() != 0 || push || owed_bytes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_indent(input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid      <= 1'b0;
        spaces_per_lvl <= val;
    endtask

    // Stimulus sequence
    initial
    begin
        send_idle <= 24;
        recv_idle <= 86;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: underflow, stray backslash, blanks, byte extremes, escapes, nesting
        pend_bytes = {CHR_RBRACK, CHR_BSLASH, CHR_SPACE, CHR_TAB, CHR_NL, CHR_VT, CHR_FF,
                      CHR_CR, 8'h00, 8'hFF, CHR_LBRACE, CHR_QUOTE, 8'h6B, CHR_BSLASH,
                      CHR_QUOTE, CHR_LBRACK, CHR_QUOTE, 8'h3A, CHR_LBRACK, 8'h31, CHR_COMMA,
                      8'h32, CHR_RBRACK, CHR_RBRACE, CHR_RBRACE};
        wait_drained();

        // widest indent, deep nesting first so the overflow can be hit
        write_indent(2'd3);
        @(posedge clk);
        queue_text(145, 1'b1);
        wait_drained();

        // no indent, lazy sender, busy receiver
        send_idle <= 86;
        recv_idle <= 24;
        write_indent(2'd0);
        @(posedge clk);
        queue_text(145, 1'b1);
        wait_drained();

        // one space per level, full rate on both sides
        send_idle <= 0;
        recv_idle <= 0;
        write_indent(2'd1);
        @(posedge clk);
        queue_text(150, 1'b0);
        wait_drained();

        if (err_cnt == 0)
            $display("json_stream_indenter_core verification clean");
        else
            $display("json_stream_indenter_core verification failed");
        $finish;
    end

endmodule
